>>> rtl/core/lspm_pkg.sv
// ----------------------------------------------------------------------------
// lspm_pkg
// Shared types and constants for the laser scan polar-to-map converter.
// ----------------------------------------------------------------------------
package lspm_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_ANGLE_STEP = 3'd0;
   localparam logic [2:0] CSR_ROT_XX     = 3'd1;
   localparam logic [2:0] CSR_ROT_XY     = 3'd2;
   localparam logic [2:0] CSR_ROT_YX     = 3'd3;
   localparam logic [2:0] CSR_ROT_YY     = 3'd4;
   localparam logic [2:0] CSR_SHIFT_X    = 3'd5;
   localparam logic [2:0] CSR_SHIFT_Y    = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   // CORDIC datapath: Q1.30 with headroom
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_PAIRS = CORDIC_STEPS / 2;
   localparam logic signed [CORDIC_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;

   // round(2^32 * atan(2^-i) / (2*pi))
   localparam logic signed [CORDIC_W-1:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
      34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
      34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
      34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
      34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
      34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
      34'sd652,       34'sd326,       34'sd163,       34'sd81,
      34'sd41,        34'sd20,        34'sd10,        34'sd5,
      34'sd3,         34'sd1
   };

   // sensor frame and map frame widths
   localparam int RANGE_W = 16;
   localparam int TAG_W   = 12;
   localparam int PROD_W  = RANGE_W + 1 + CORDIC_W;   // range * cos
   localparam int PX_W    = 27;                       // Q.8 mm, |px| < 2^25
   localparam int ROT_W   = 32;
   localparam int MAP_W   = 32;
   localparam int RPROD_W = ROT_W + PX_W;             // rot * px
   localparam int MM_W    = RPROD_W + 1 - 38;         // rounded whole mm

   // one word moving through the CORDIC stages
   typedef struct packed {
      logic                valid;
      logic [TAG_W-1:0]    tag;
      logic [RANGE_W-1:0]  range_mm;
      logic                flip;
      logic [CORDIC_W-1:0] x;
      logic [CORDIC_W-1:0] y;
      logic [CORDIC_W-1:0] z;
   } cordic_item_type;

endpackage

>>> rtl/core/lspm_channels.sv
// ----------------------------------------------------------------------------
// lspm channels
// Valid/ready channel interfaces for beam words in and point words out.
// ----------------------------------------------------------------------------
interface lspm_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] beam_index;
   logic [15:0] range_mm;
   logic        no_return;

   modport source (output valid, output beam_index, output range_mm, output no_return,
                   input ready);
   modport sink   (input valid, input beam_index, input range_mm, input no_return,
                   output ready);
endinterface

interface lspm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] map_x;
   logic signed [31:0] map_y;
   logic [11:0]        beam_tag;

   modport source (output valid, output map_x, output map_y, output beam_tag,
                   input ready);
   modport sink   (input valid, input map_x, input map_y, input beam_tag,
                   output ready);
endinterface

>>> rtl/core/lspm_cordic_pair.sv
// ----------------------------------------------------------------------------
// lspm_cordic_pair
// Two rotation-mode CORDIC iterations followed by one pipeline register.
// ----------------------------------------------------------------------------
module lspm_cordic_pair #(
   parameter int FIRST_STEP = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  lspm_pkg::cordic_item_type prev_item,
   output lspm_pkg::cordic_item_type item_ff
);

   localparam int STEP_A = FIRST_STEP;
   localparam int STEP_B = FIRST_STEP + 1;

   lspm_pkg::cordic_item_type item_in;

   logic signed [lspm_pkg::CORDIC_W-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2;

   always_comb begin
      x0 = $signed(prev_item.x);
      y0 = $signed(prev_item.y);
      z0 = $signed(prev_item.z);

      if (!z0[lspm_pkg::CORDIC_W-1]) begin
         x1 = x0 - (y0 >>> STEP_A);
         y1 = y0 + (x0 >>> STEP_A);
         z1 = z0 - lspm_pkg::ATAN_TURN[STEP_A];
      end else begin
         x1 = x0 + (y0 >>> STEP_A);
         y1 = y0 - (x0 >>> STEP_A);
         z1 = z0 + lspm_pkg::ATAN_TURN[STEP_A];
      end

      if (!z1[lspm_pkg::CORDIC_W-1]) begin
         x2 = x1 - (y1 >>> STEP_B);
         y2 = y1 + (x1 >>> STEP_B);
         z2 = z1 - lspm_pkg::ATAN_TURN[STEP_B];
      end else begin
         x2 = x1 + (y1 >>> STEP_B);
         y2 = y1 - (x1 >>> STEP_B);
         z2 = z1 + lspm_pkg::ATAN_TURN[STEP_B];
      end

      item_in   = prev_item;
      item_in.x = x2;
      item_in.y = y2;
      item_in.z = z2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff.valid <= item_in.valid;
      end
      if (advance) begin
         item_ff.tag      <= item_in.tag;
         item_ff.range_mm <= item_in.range_mm;
         item_ff.flip     <= item_in.flip;
         item_ff.x        <= item_in.x;
         item_ff.y        <= item_in.y;
         item_ff.z        <= item_in.z;
      end
   end

endmodule

>>> rtl/core/laser_scan_polar_to_map_xy_core.sv
// ----------------------------------------------------------------------------
// laser_scan_polar_to_map_xy_core
// Converts laser beams (index, range) into map-frame x/y points.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one beam word per handshake (beam_index, range_mm, no_return).
//   rsp  : one point word (map_x, map_y, beam_tag) per beam that has a return.
//   csr  : write-only registers, written while no beam is in flight.
// Beams flagged no_return, or with an index at or past MAX_BEAMS, are
// dropped and give no rsp word.
// Throughput: one beam per cycle while rsp does not stall. From accept to
// rsp.valid a beam passes the 15 CORDIC stages (two iterations each), the angle
// multiply, quadrant fold, two range-scaling stages, two rotation stages and the
// saturating output register.
// Reset (synchronous) clears all stage valid bits and loads the identity
// rotation, zero shift and zero angle step.
// When rsp stalls, the whole pipe holds: req.ready drops in the same cycle,
// nothing is lost or repeated. Bubbles do not compress during a stall.
// ----------------------------------------------------------------------------
module laser_scan_polar_to_map_xy_core #(
   parameter int MAX_BEAMS = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   lspm_req_if.sink                              req,
   lspm_rsp_if.source                            rsp,
   input  logic                                  csr_write,
   input  logic [lspm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lspm_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int CW  = lspm_pkg::CORDIC_W;
   localparam int NP  = lspm_pkg::CORDIC_PAIRS;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic        [31:0] angle_step_ff;
   logic signed [31:0] rot_xx_ff, rot_xy_ff, rot_yx_ff, rot_yy_ff;
   logic signed [31:0] shift_x_ff, shift_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_step_ff <= '0;
         rot_xx_ff     <= lspm_pkg::ONE_Q30;
         rot_xy_ff     <= '0;
         rot_yx_ff     <= '0;
         rot_yy_ff     <= lspm_pkg::ONE_Q30;
         shift_x_ff    <= '0;
         shift_y_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lspm_pkg::CSR_ANGLE_STEP: angle_step_ff <= csr_data;
            lspm_pkg::CSR_ROT_XX:     rot_xx_ff     <= csr_data;
            lspm_pkg::CSR_ROT_XY:     rot_xy_ff     <= csr_data;
            lspm_pkg::CSR_ROT_YX:     rot_yx_ff     <= csr_data;
            lspm_pkg::CSR_ROT_YY:     rot_yy_ff     <= csr_data;
            lspm_pkg::CSR_SHIFT_X:    shift_x_ff    <= csr_data;
            lspm_pkg::CSR_SHIFT_Y:    shift_y_ff    <= csr_data;
            default: ;  // unmapped index, ignored
         endcase
      end
   end

   // ------------------------------------------------------------------
   // global stall: every stage moves when the output register can
   // ------------------------------------------------------------------
   logic out_valid_ff;
   logic advance;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // ------------------------------------------------------------------
   // stage 1: beam angle = index * step (mod 2^32)
   // ------------------------------------------------------------------
   logic        s1_valid_ff, s1_valid_in;
   logic [11:0] s1_tag_ff;
   logic [15:0] s1_range_ff;
   logic [31:0] s1_theta_ff, s1_theta_in;
   logic [43:0] theta_full;

   assign theta_full  = req.beam_index * angle_step_ff;
   assign s1_theta_in = theta_full[31:0];
   assign s1_valid_in = req.valid && !req.no_return && (32'(req.beam_index) < MAX_BEAMS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
      if (advance) begin
         s1_tag_ff   <= req.beam_index;
         s1_range_ff <= req.range_mm;
         s1_theta_ff <= s1_theta_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: fold quadrants 1 and 2 by half a turn, seed the CORDIC
   // ------------------------------------------------------------------
   lspm_pkg::cordic_item_type red_ff, red_in;
   logic                      fold;
   logic [31:0]               residue;

   always_comb begin
      fold            = s1_theta_ff[31] ^ s1_theta_ff[30];
      residue         = {s1_theta_ff[31] ^ fold, s1_theta_ff[30:0]};
      red_in.valid    = s1_valid_ff;
      red_in.tag      = s1_tag_ff;
      red_in.range_mm = s1_range_ff;
      red_in.flip     = fold;
      red_in.x        = lspm_pkg::CORDIC_INV_GAIN;
      red_in.y        = '0;
      red_in.z        = {{(CW-32){residue[31]}}, residue};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff.valid <= 1'b0;
      end else if (advance) begin
         red_ff.valid <= red_in.valid;
      end
      if (advance) begin
         red_ff.tag      <= red_in.tag;
         red_ff.range_mm <= red_in.range_mm;
         red_ff.flip     <= red_in.flip;
         red_ff.x        <= red_in.x;
         red_ff.y        <= red_in.y;
         red_ff.z        <= red_in.z;
      end
   end

   // ------------------------------------------------------------------
   // CORDIC: 30 iterations as 15 registered pairs
   // ------------------------------------------------------------------
   lspm_pkg::cordic_item_type cord [0:NP];

   assign cord[0] = red_ff;

   for (genvar g = 0; g < NP; g++) begin : g_cordic
      lspm_cordic_pair #(
         .FIRST_STEP (2 * g)
      ) u_pair (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prev_item (cord[g]),
         .item_ff   (cord[g+1])
      );
   end

   lspm_pkg::cordic_item_type cend;
   assign cend = cord[NP];

   // ------------------------------------------------------------------
   // stage M1: range * cos, range * sin (sign fix deferred)
   // ------------------------------------------------------------------
   localparam int PW = lspm_pkg::PROD_W;

   logic                 m1_valid_ff, m1_flip_ff;
   logic [11:0]          m1_tag_ff;
   logic signed [PW-1:0] m1_pc_ff, m1_pc_in, m1_ps_ff, m1_ps_in;

   assign m1_pc_in = $signed({1'b0, cend.range_mm}) * $signed(cend.x);
   assign m1_ps_in = $signed({1'b0, cend.range_mm}) * $signed(cend.y);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else if (advance) begin
         m1_valid_ff <= cend.valid;
      end
      if (advance) begin
         m1_flip_ff <= cend.flip;
         m1_tag_ff  <= cend.tag;
         m1_pc_ff   <= m1_pc_in;
         m1_ps_ff   <= m1_ps_in;
      end
   end

   // ------------------------------------------------------------------
   // stage M2: apply fold sign, round to Q.8 mm
   // ------------------------------------------------------------------
   localparam int XW = lspm_pkg::PX_W;
   localparam logic signed [PW:0] HALF_22 = (PW+1)'(1) <<< 21;

   logic                 m2_valid_ff;
   logic [11:0]          m2_tag_ff;
   logic signed [XW-1:0] m2_px_ff, m2_px_in, m2_py_ff, m2_py_in;
   logic signed [PW:0]   rnd_c, rnd_s;

   always_comb begin
      if (m1_flip_ff) begin
         rnd_c = HALF_22 - (PW+1)'(m1_pc_ff);
         rnd_s = HALF_22 - (PW+1)'(m1_ps_ff);
      end else begin
         rnd_c = (PW+1)'(m1_pc_ff) + HALF_22;
         rnd_s = (PW+1)'(m1_ps_ff) + HALF_22;
      end
      m2_px_in = rnd_c[22 +: XW];
      m2_py_in = rnd_s[22 +: XW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else if (advance) begin
         m2_valid_ff <= m1_valid_ff;
      end
      if (advance) begin
         m2_tag_ff <= m1_tag_ff;
         m2_px_ff  <= m2_px_in;
         m2_py_ff  <= m2_py_in;
      end
   end

   // ------------------------------------------------------------------
   // stage M3: the four rotation products
   // ------------------------------------------------------------------
   localparam int RW = lspm_pkg::RPROD_W;

   logic                 m3_valid_ff;
   logic [11:0]          m3_tag_ff;
   logic signed [RW-1:0] m3_xx_ff, m3_xy_ff, m3_yx_ff, m3_yy_ff;
   logic signed [RW-1:0] m3_xx_in, m3_xy_in, m3_yx_in, m3_yy_in;

   assign m3_xx_in = rot_xx_ff * m2_px_ff;
   assign m3_xy_in = rot_xy_ff * m2_py_ff;
   assign m3_yx_in = rot_yx_ff * m2_px_ff;
   assign m3_yy_in = rot_yy_ff * m2_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m3_valid_ff <= 1'b0;
      end else if (advance) begin
         m3_valid_ff <= m2_valid_ff;
      end
      if (advance) begin
         m3_tag_ff <= m2_tag_ff;
         m3_xx_ff  <= m3_xx_in;
         m3_xy_ff  <= m3_xy_in;
         m3_yx_ff  <= m3_yx_in;
         m3_yy_ff  <= m3_yy_in;
      end
   end

   // ------------------------------------------------------------------
   // stage M4: row sums, round Q.38 to whole mm
   // ------------------------------------------------------------------
   localparam int MW = lspm_pkg::MM_W;
   localparam logic signed [RW:0] HALF_38 = (RW+1)'(1) <<< 37;

   logic                 m4_valid_ff;
   logic [11:0]          m4_tag_ff;
   logic signed [MW-1:0] m4_mx_ff, m4_mx_in, m4_my_ff, m4_my_in;
   logic signed [RW:0]   sum_x, sum_y;

   always_comb begin
      sum_x    = (RW+1)'(m3_xx_ff) + (RW+1)'(m3_xy_ff) + HALF_38;
      sum_y    = (RW+1)'(m3_yx_ff) + (RW+1)'(m3_yy_ff) + HALF_38;
      m4_mx_in = sum_x[RW:38];
      m4_my_in = sum_y[RW:38];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m4_valid_ff <= 1'b0;
      end else if (advance) begin
         m4_valid_ff <= m3_valid_ff;
      end
      if (advance) begin
         m4_tag_ff <= m3_tag_ff;
         m4_mx_ff  <= m4_mx_in;
         m4_my_ff  <= m4_my_in;
      end
   end

   // ------------------------------------------------------------------
   // output register: add shift, saturate to 32 bits
   // ------------------------------------------------------------------
   localparam int OW = lspm_pkg::MAP_W;

   logic signed [OW:0]   tot_x, tot_y;
   logic signed [OW-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [11:0]          out_tag_ff;

   function automatic logic [lspm_pkg::MAP_W-1:0] sat32(
      input logic signed [lspm_pkg::MAP_W:0] v
   );
      logic [lspm_pkg::MAP_W-1:0] r;
      if (v[lspm_pkg::MAP_W] == v[lspm_pkg::MAP_W-1]) begin
         r = v[lspm_pkg::MAP_W-1:0];
      end else if (v[lspm_pkg::MAP_W]) begin
         r = {1'b1, {(lspm_pkg::MAP_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(lspm_pkg::MAP_W-1){1'b1}}};
      end
      return r;
   endfunction

   always_comb begin
      tot_x    = (OW+1)'(m4_mx_ff) + (OW+1)'(shift_x_ff);
      tot_y    = (OW+1)'(m4_my_ff) + (OW+1)'(shift_y_ff);
      out_x_in = sat32(tot_x);
      out_y_in = sat32(tot_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= m4_valid_ff;
      end
      if (advance) begin
         out_tag_ff <= m4_tag_ff;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.map_x    = out_x_ff;
   assign rsp.map_y    = out_y_ff;
   assign rsp.beam_tag = out_tag_ff;

endmodule
